@@ rtl/core/hcp_pkg.sv @@
package hcp_pkg;

  typedef struct packed {
    logic [7:0] text_char;
    logic       is_last;
    logic       no_text;
  } in_t;

  typedef struct packed {
    logic        parse_ok;
    logic [31:0] packed_color;
  } out_t;

  typedef struct packed {
    logic        produce;
    logic        parse_ok;
    logic [31:0] packed_color;
  } scan_res_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_HASH  = 8'h23;

  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_BODY  = 2'd1;
  localparam logic [1:0] PH_TRAIL = 2'd2;

  localparam logic [3:0] MAX_DIGITS = 4'd8;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

endpackage

@@ rtl/core/hcp_scan.sv @@
module hcp_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  hcp_pkg::in_t      item,
  output hcp_pkg::scan_res_t res
);

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] count_r, count_nxt;
  logic       err_r, err_nxt;
  logic [3:0] nib_r [8];

  logic       ws, hash, is_hex;
  logic [3:0] hex_val;
  logic       wr_en;
  logic [1:0] phase_t;
  logic [3:0] count_t;
  logic       err_t;
  logic [3:0] nv [8];
  logic [7:0] r, g, b, a;
  logic       count_ok;

  always_comb begin
    ws = (item.text_char == hcp_pkg::CH_SPACE) || (item.text_char == hcp_pkg::CH_TAB);
    hash = item.text_char == hcp_pkg::CH_HASH;
    is_hex = 1'b1;
    hex_val = 4'd0;
    if (item.text_char >= 8'h30 && item.text_char <= 8'h39) begin
      hex_val = 4'(item.text_char - 8'h30);
    end else if (item.text_char >= 8'h61 && item.text_char <= 8'h66) begin
      hex_val = 4'(item.text_char - 8'h57);
    end else if (item.text_char >= 8'h41 && item.text_char <= 8'h46) begin
      hex_val = 4'(item.text_char - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  // per-character phase update
  always_comb begin
    phase_t = phase_r;
    count_t = count_r;
    err_t   = err_r;
    wr_en   = 1'b0;
    if (phase_r[1]) begin
      if (!ws) err_t = 1'b1;
    end else if (ws) begin
      if (phase_r == hcp_pkg::PH_BODY) phase_t = hcp_pkg::PH_TRAIL;
    end else if (hash) begin
      if (phase_r == hcp_pkg::PH_LEAD) phase_t = hcp_pkg::PH_BODY;
      else err_t = 1'b1;
    end else if (is_hex) begin
      phase_t = hcp_pkg::PH_BODY;
      if (count_r < hcp_pkg::MAX_DIGITS) begin
        wr_en   = 1'b1;
        count_t = count_r + 4'd1;
      end else begin
        err_t = 1'b1;
      end
    end else begin
      err_t = 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      nv[i] = (wr_en && (count_r[2:0] == 3'(i))) ? hex_val : nib_r[i];
    end
  end

  // color packing from the updated digit view
  always_comb begin
    count_ok = (count_t == 4'd3) || (count_t == 4'd4) || (count_t == 4'd6) ||
               (count_t == 4'd8);
    if (count_t <= 4'd4) begin
      r = {nv[0], nv[0]};
      g = {nv[1], nv[1]};
      b = {nv[2], nv[2]};
      a = (count_t == 4'd4) ? {nv[3], nv[3]} : hcp_pkg::ALPHA_OPAQUE;
    end else begin
      r = {nv[0], nv[1]};
      g = {nv[2], nv[3]};
      b = {nv[4], nv[5]};
      a = (count_t == 4'd8) ? {nv[6], nv[7]} : hcp_pkg::ALPHA_OPAQUE;
    end
  end

  always_comb begin
    res = '0;
    phase_nxt = phase_t;
    count_nxt = count_t;
    err_nxt   = err_t;
    if (item.no_text) begin
      res.produce = 1'b1;
      phase_nxt = hcp_pkg::PH_LEAD;
      count_nxt = 4'd0;
      err_nxt   = 1'b0;
    end else if (item.is_last) begin
      res.produce = 1'b1;
      if (!err_t && count_ok) begin
        res.parse_ok = 1'b1;
        res.packed_color = (a == hcp_pkg::ALPHA_OPAQUE) ? {8'h00, r, g, b} : {a, r, g, b};
      end
      phase_nxt = hcp_pkg::PH_LEAD;
      count_nxt = 4'd0;
      err_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hcp_pkg::PH_LEAD;
      count_r <= 4'd0;
      err_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && !item.no_text && wr_en) begin
      nib_r[count_r[2:0]] <= hex_val;
    end
  end

endmodule

@@ rtl/core/hex_color_text_parser.sv @@
// an accepted input transaction is registered in s1_data_r, and its result in out_data_r
// throughput: one character per cycle while the result side does not stall
// the scan state and digit store update in the single stage after the input register
// reset: synchronous active-low rst_n clears the scan phase, digit count, error flag
// and both valid flags; the digit store holds no reset value
module hex_color_text_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  hcp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output hcp_pkg::out_t out_data
);

  logic               s1_valid_r, s1_valid_nxt;
  hcp_pkg::in_t       s1_data_r;
  logic               out_valid_r, out_valid_nxt;
  hcp_pkg::out_t      out_data_r;
  hcp_pkg::scan_res_t res;
  logic               out_ready, s1_move, in_accept;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && (!res.produce || out_ready);
  assign in_stall  = s1_valid_r && !s1_move;
  assign in_accept = in_valid && !in_stall;

  hcp_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_move),
    .item  (s1_data_r),
    .res   (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) s1_valid_nxt = 1'b1;
    else if (s1_move) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (s1_move && res.produce) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) s1_data_r <= in_data;
    if (s1_move && res.produce) begin
      out_data_r.parse_ok     <= res.parse_ok;
      out_data_r.packed_color <= res.packed_color;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/core/hcp_checker.sv @@
module hcp_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input hcp_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input hcp_pkg::out_t out_data
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.parse_ok) |-> (out_data.packed_color == 32'd0))
    else $error("failed parse with nonzero color");

  a_alpha_never_opaque_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.packed_color[31:24] != 8'hFF))
    else $error("opaque alpha packed into top byte");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_data)))
    else $error("stalled input transaction changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result transaction changed");

endmodule

bind hex_color_text_parser hcp_checker u_hcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ dv/hex_color_text_parser_test.sv @@
module hex_color_text_parser_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 150;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  hcp_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  hcp_pkg::out_t out_data;

  hex_color_text_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  hcp_pkg::out_t color_q[$];
  logic [7:0]    text_buf[$];
  int            errors;
  int            idle_cycles;
  int            burst_left;
  int            items_sent;
  int            hold_reqs;
  int            holds_served;

  logic [1:0] sc_phase;
  int         sc_count;
  logic [3:0] sc_nibs[8];
  logic       sc_err;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int hex_value(logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return int'(ch - "0");
    if (ch >= "a" && ch <= "f") return int'(ch - "a") + 10;
    if (ch >= "A" && ch <= "F") return int'(ch - "A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v, logic upper);
    if (v < 4'd10) return "0" + {4'd0, v};
    return (upper ? "A" : "a") + {4'd0, v} - 8'd10;
  endfunction

  function automatic void clear_scan();
    sc_phase = hcp_pkg::PH_LEAD;
    sc_count = 0;
    sc_err   = 1'b0;
  endfunction

  function automatic void scan_char(logic [7:0] ch);
    logic blank;
    int   v;
    blank = (ch == hcp_pkg::CH_SPACE) || (ch == hcp_pkg::CH_TAB);
    v = hex_value(ch);
    if (sc_phase >= hcp_pkg::PH_TRAIL) begin
      if (!blank) sc_err = 1'b1;
    end else if (blank) begin
      if (sc_phase == hcp_pkg::PH_BODY) sc_phase = hcp_pkg::PH_TRAIL;
    end else if (ch == hcp_pkg::CH_HASH) begin
      if (sc_phase == hcp_pkg::PH_LEAD) sc_phase = hcp_pkg::PH_BODY;
      else sc_err = 1'b1;
    end else if (v >= 0) begin
      sc_phase = hcp_pkg::PH_BODY;
      if (sc_count < hcp_pkg::MAX_DIGITS) begin
        sc_nibs[sc_count[2:0]] = v[3:0];
        sc_count++;
      end else begin
        sc_err = 1'b1;
      end
    end else begin
      sc_err = 1'b1;
    end
  endfunction

  function automatic void predict_color(hcp_pkg::in_t item);
    hcp_pkg::out_t res;
    logic [7:0]    r;
    logic [7:0]    g;
    logic [7:0]    b;
    logic [7:0]    a;
    res = '0;
    if (item.no_text) begin
      clear_scan();
      color_q.push_back(res);
      return;
    end
    scan_char(item.text_char);
    if (!item.is_last) return;
    if (!sc_err && (sc_count == 3 || sc_count == 4 || sc_count == 6 || sc_count == 8)) begin
      a = hcp_pkg::ALPHA_OPAQUE;
      if (sc_count <= 4) begin
        r = {sc_nibs[0], sc_nibs[0]};
        g = {sc_nibs[1], sc_nibs[1]};
        b = {sc_nibs[2], sc_nibs[2]};
        if (sc_count == 4) a = {sc_nibs[3], sc_nibs[3]};
      end else begin
        r = {sc_nibs[0], sc_nibs[1]};
        g = {sc_nibs[2], sc_nibs[3]};
        b = {sc_nibs[4], sc_nibs[5]};
        if (sc_count == 8) a = {sc_nibs[6], sc_nibs[7]};
      end
      res.parse_ok     = 1'b1;
      res.packed_color = (a == hcp_pkg::ALPHA_OPAQUE) ? {8'h00, r, g, b} : {a, r, g, b};
    end
    clear_scan();
    color_q.push_back(res);
  endfunction

  // input and result monitor, plus the no-progress watchdog
  always @(posedge clk) begin
    hcp_pkg::out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) predict_color(in_data);
      if (out_valid && !out_stall) begin
        if (color_q.size() == 0) begin
          $error("unexpected result transaction: parse_ok=%0b packed_color=%08h",
                 out_data.parse_ok, out_data.packed_color);
          errors++;
        end else begin
          want = color_q.pop_front();
          if (out_data.parse_ok !== want.parse_ok) begin
            $error("parse_ok: expected %0b, actual %0b", want.parse_ok, out_data.parse_ok);
            errors++;
          end
          if (out_data.packed_color !== want.packed_color) begin
            $error("packed_color: expected %08h, actual %08h",
                   want.packed_color, out_data.packed_color);
            errors++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("hex_color_text_parser regression: fail");
        $finish;
      end
    end
  end

  // result side stall pattern with an occasional long hold-off
  initial begin
    int seg;
    int mode;
    int hold_left;
    out_stall = 1'b0;
    seg = 0;
    mode = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_reqs) begin
        holds_served = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (seg == 0) begin
          seg = $urandom_range(10, 120);
          mode = $urandom_range(0, 3);
        end
        seg--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_char(logic [7:0] ch, logic last, logic none);
    hcp_pkg::in_t item;
    item.text_char = ch;
    item.is_last   = last;
    item.no_text   = none;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 48);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    items_sent++;
    @(negedge clk);
  endtask

  task automatic put_str(string s);
    int i;
    for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic put_blank();
    text_buf.push_back($urandom_range(0, 1) ? hcp_pkg::CH_SPACE : hcp_pkg::CH_TAB);
  endtask

  // may_cut lets a text be dropped part way by an absent-text transaction
  task automatic send_text(bit may_cut);
    int i;
    int cut;
    if (text_buf.size() == 0) begin
      send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      return;
    end
    cut = text_buf.size();
    if (may_cut && $urandom_range(0, 15) == 0) cut = $urandom_range(0, text_buf.size() - 1);
    for (i = 0; i < cut; i++) send_char(text_buf[i], i == text_buf.size() - 1, 1'b0);
    if (cut < text_buf.size()) begin
      send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end
    text_buf.delete();
  endtask

  task automatic make_text();
    int         kind;
    int         cnt;
    int         i;
    int         alpha_from;
    logic       opaque;
    logic [3:0] v;
    text_buf.delete();
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 2)) put_blank();
    if ($urandom_range(0, 3) != 0) text_buf.push_back(hcp_pkg::CH_HASH);
    case ($urandom_range(0, 3))
      0: cnt = 3;
      1: cnt = 4;
      2: cnt = 6;
      default: cnt = 8;
    endcase
    if (kind >= 7) cnt = $urandom_range(0, 10);
    opaque = ($urandom_range(0, 2) == 0);
    alpha_from = (cnt >= 8) ? 6 : (cnt == 4) ? 3 : cnt;
    for (i = 0; i < cnt; i++) begin
      v = 4'($urandom_range(0, 15));
      if (opaque && i >= alpha_from) v = 4'hF;
      text_buf.push_back(hex_char(v, 1'($urandom_range(0, 1))));
    end
    repeat ($urandom_range(0, 2)) put_blank();
    if (kind == 8) begin
      case ($urandom_range(0, 2))
        0: text_buf.insert($urandom_range(0, text_buf.size()), hcp_pkg::CH_HASH);
        1: text_buf.insert($urandom_range(0, text_buf.size()), 8'($urandom_range(0, 255)));
        default: text_buf.insert($urandom_range(0, text_buf.size()), hcp_pkg::CH_SPACE);
      endcase
    end
  endtask

  task automatic test_short_forms();
    put_str("#0fA");
    send_text(1'b0);
    put_str("FfFf");
    send_text(1'b0);
  endtask

  task automatic test_long_forms();
    put_str("\t#80fF00Fe");
    send_text(1'b0);
  endtask

  task automatic test_malformed_texts();
    put_str(" \t#");
    send_text(1'b0);
    put_str("1 2");
    send_text(1'b0);
    put_str("8#");
    send_text(1'b0);
    send_char(8'h00, 1'b1, 1'b0);
    send_char(8'hFF, 1'b1, 1'b0);
  endtask

  task automatic test_absent_text();
    send_char("a", 1'b0, 1'b0);
    send_char(8'hFF, 1'b0, 1'b1);
    send_char(8'h00, 1'b1, 1'b1);
  endtask

  task automatic test_random_texts(int n_items);
    int start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      make_text();
      send_text(1'b1);
    end
  endtask

  task automatic test_stall_pressure(int n_items);
    hold_reqs++;
    test_random_texts(n_items);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    clear_scan();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_short_forms();
    test_long_forms();
    test_malformed_texts();
    test_absent_text();
    wait_drain();
    test_random_texts(1000);
    test_stall_pressure(80);
    test_random_texts(40);
    wait_drain();
    if (errors == 0) begin
      $display("hex_color_text_parser regression: pass");
    end else begin
      $display("hex_color_text_parser regression: fail");
    end
    $finish;
  end

endmodule
